// File: sv/tdsw_pkg.sv
// Shared types and constants for the two-wire display serial writer.
package tdsw_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CMD_DATA_SET   = 8'h40;
  localparam logic [7:0] CMD_ADDR_SET   = 8'h80;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;

  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic item_done;
  } out_item_t;

  // Classified byte job handed from front to back
  typedef struct packed {
    logic       has_start;
    logic       has_stop;
    logic [7:0] byte_value;
  } job_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_BITS,
    PH_ACK,
    PH_STOP
  } phase_t;

endpackage

// File: sv/tdsw_front.sv
// Front end: accepts input items, classifies them and queues byte jobs.
module tdsw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tdsw_pkg::in_item_t in_data,
  output logic              job_valid,
  output tdsw_pkg::job_t    job,
  input  logic              job_pop
);
  import tdsw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  job_t             new_job;

  always_comb begin
    new_job.has_start  = (in_data.req_type == REQ_CMD);
    new_job.byte_value = in_data.byte_value;
    if (in_data.req_type == REQ_CMD) begin
      new_job.has_stop = (in_data.byte_value == CMD_DATA_SET) ||
                         (in_data.byte_value == CMD_ADDR_SET) ||
                         (in_data.byte_value == CMD_DISPLAY_ON);
    end else begin
      new_job.has_stop = in_data.last_byte;
    end
  end

  assign in_ready  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (count_r != '0);
  assign job       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (job_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !job_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && job_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_job;
    end
  end

endmodule

// File: sv/tdsw_back.sv
// Back end: sequences pin writes for each byte job into the output register.
module tdsw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  tdsw_pkg::job_t     job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tdsw_pkg::out_item_t out_data
);
  import tdsw_pkg::*;

  logic                 busy_r, busy_nxt;
  phase_t               phase_r, phase_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  job_t                 cur_r, cur_nxt;
  logic                 clk_pin_r, clk_pin_nxt;
  logic                 dio_pin_r, dio_pin_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 slot_free;
  logic                 emit;
  logic                 last_write;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = busy_r && slot_free;

  always_comb begin
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    sub_nxt       = sub_r;
    bit_nxt       = bit_r;
    cur_nxt       = cur_r;
    clk_pin_nxt   = clk_pin_r;
    dio_pin_nxt   = dio_pin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    last_write    = 1'b0;
    job_pop       = 1'b0;

    if (emit) begin
      // Pin write and position advance for the current step
      unique case (phase_r)
        PH_START: begin
          unique case (sub_r)
            2'd0:    clk_pin_nxt = 1'b1;
            2'd1:    dio_pin_nxt = 1'b1;
            2'd2:    dio_pin_nxt = 1'b0;
            default: clk_pin_nxt = 1'b0;
          endcase
          if (sub_r == 2'd3) begin
            phase_nxt = PH_BITS;
            sub_nxt   = '0;
            bit_nxt   = '0;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
        PH_BITS: begin
          unique case (sub_r)
            2'd0:    clk_pin_nxt = 1'b0;
            2'd1:    dio_pin_nxt = cur_r.byte_value[bit_r];
            default: clk_pin_nxt = 1'b1;
          endcase
          if (sub_r == 2'd2) begin
            sub_nxt = '0;
            if (bit_r == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
              phase_nxt = PH_ACK;
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
        PH_ACK: begin
          clk_pin_nxt = sub_r[0];
          if (sub_r[0]) begin
            sub_nxt = '0;
            if (cur_r.has_stop) begin
              phase_nxt = PH_STOP;
            end else begin
              last_write = 1'b1;
            end
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
        default: begin
          unique case (sub_r)
            2'd0:    clk_pin_nxt = 1'b0;
            2'd1:    dio_pin_nxt = 1'b0;
            2'd2:    clk_pin_nxt = 1'b1;
            default: dio_pin_nxt = 1'b1;
          endcase
          if (sub_r == 2'd3) begin
            last_write = 1'b1;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
      endcase

      out_valid_nxt          = 1'b1;
      out_data_nxt.clk_level = clk_pin_nxt;
      out_data_nxt.dio_level = dio_pin_nxt;
      out_data_nxt.item_done = last_write;
    end

    // Load the next job when idle or right after the final write
    if (!busy_r || last_write) begin
      busy_nxt = job_valid;
      if (job_valid) begin
        job_pop   = 1'b1;
        cur_nxt   = job;
        phase_nxt = job.has_start ? PH_START : PH_BITS;
        sub_nxt   = '0;
        bit_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_START;
      sub_r       <= '0;
      bit_r       <= '0;
      clk_pin_r   <= 1'b0;
      dio_pin_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      bit_r       <= bit_nxt;
      clk_pin_r   <= clk_pin_nxt;
      dio_pin_r   <= dio_pin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/two_wire_display_serial_writer.sv
// Top level of the two-wire display serial writer: front queue plus pin sequencer.
// Each accepted byte turns into a run of pin writes, one result per write, at up to one
// write per cycle while out_ready holds: a command makes 30 writes (34 when it is 0x40,
// 0x80 or 0x88), a data byte 26 (30 when marked last). The pin sequencer in the back end
// sets this rate; a two-entry job queue in front keeps taking bytes while it works, so
// back-to-back bytes follow with no gap, and a byte at an idle block is queued, then loaded.
module two_wire_display_serial_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tdsw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tdsw_pkg::out_item_t out_data
);
  import tdsw_pkg::*;

  logic job_valid;
  logic job_pop;
  job_t job;

  tdsw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  tdsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("job popped from empty queue");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> job_valid)
    else $error("input stalled while queue is empty");

  a_done_clk_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.item_done) |-> out_data.clk_level)
    else $error("byte finished with clock low");
`endif

endmodule
